### rtl/core/mpd_pkg.sv
`timescale 1ns / 1ps
// Morse press decoder package: sequencer states, codes, symbol weights and
// the letter hash table. No dependencies.
package mpd_pkg;

  localparam int DUR_W       = 26;
  localparam int HASH_W      = 16;
  localparam int CNT_W       = 3;
  localparam int CODE_W      = 7;
  localparam int COEF_W      = 9;
  localparam int WEIGHT_W    = 7;
  localparam int MAX_SYMBOLS = 6;
  localparam int NUM_CHARS   = 36;

  localparam logic [DUR_W-1:0] DAH_THR_RESET = 26'd500000;
  localparam logic [DUR_W-1:0] FIN_THR_RESET = 26'd1500000;

  localparam logic [WEIGHT_W-1:0] DAH_WEIGHT = 7'd97;
  localparam logic [WEIGHT_W-1:0] DIT_WEIGHT = 7'd105;

  localparam logic [CODE_W-1:0] CHAR_UNKNOWN = 7'd126;
  localparam logic [CODE_W-1:0] CHAR_SPACE   = 7'd32;
  localparam logic [CODE_W-1:0] CHAR_END     = 7'd0;

  // Button kind carried on in_tuser
  localparam logic REQ_SIGNAL  = 1'b0;
  localparam logic REQ_CONTROL = 1'b1;

  // Configuration register indexes
  localparam logic CFG_DAH_IDX = 1'b0;
  localparam logic CFG_FIN_IDX = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP_FIN,
    ST_CMP_DAH,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } mpd_state_t;

  localparam logic [HASH_W-1:0] CODE_HASH [NUM_CHARS] = '{
    16'd2150,  16'd18884, 16'd18452, 16'd7964,  16'd210,   16'd18468,
    16'd7804,  16'd18900, 16'd2310,  16'd17476, 16'd7532,  16'd18740,
    16'd2134,  16'd2294,  16'd7372,  16'd18308, 16'd17892, 16'd7820,
    16'd7980,  16'd194,   16'd7548,  16'd18068, 16'd7388,  16'd18052,
    16'd17620, 16'd18724,
    16'd33950, 16'd33966, 16'd34126, 16'd34558, 16'd35390, 16'd36750,
    16'd36734, 16'd36574, 16'd36142, 16'd35310
  };

  localparam logic [CODE_W-1:0] CODE_CHAR [NUM_CHARS] = '{
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49,
    7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52,
    7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39
  };

  // Position factor (1 + 4k) * (2 + 2k) for symbol number k
  function automatic logic [COEF_W-1:0] symbol_coef(input logic [CNT_W-1:0] k);
    logic [COEF_W-1:0] c;
    case (k)
      3'd0:    c = 9'd2;
      3'd1:    c = 9'd20;
      3'd2:    c = 9'd54;
      3'd3:    c = 9'd104;
      3'd4:    c = 9'd170;
      3'd5:    c = 9'd252;
      3'd6:    c = 9'd350;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // Match the hash against every table entry; unknown when none hits
  function automatic logic [CODE_W-1:0] lookup_char(input logic [HASH_W-1:0] h);
    logic [CODE_W-1:0] ch;
    ch = CHAR_UNKNOWN;
    for (int i = NUM_CHARS - 1; i >= 0; i--) begin
      if (CODE_HASH[i] == h) begin
        ch = CODE_CHAR[i];
      end
    end
    return ch;
  endfunction

endpackage

### rtl/core/morse_press_decoder_unit.sv
`timescale 1ns / 1ps
// Morse press decoder top level: a small sequencer around one shared
// threshold comparator, one narrow multiplier and the hash accumulator.
// Depends on mpd_pkg.
//
// Rate: one press at a time. A signal press holds in_tready low through its
// compare, multiply and accumulate steps; past the symbol limit it is dropped
// and in_tready stays high. A control press shows its first result after the
// finish and dah compares, or after the finish compare alone when it ends the
// message; a space follows once the letter is taken if the press exceeded the
// dah threshold. The single threshold comparator runs once per compare step.
// in_tready returns the cycle after the last result is taken.
// Reset (synchronous, rst_n low): thresholds to 500000 and 1500000, letter
// state cleared, finished flag cleared, no result pending.
module morse_press_decoder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // [25:0] press_duration
  input  logic                      in_tuser,   // [0] req_type
  // Result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // [6:0] char_code
  output logic                      out_tlast,  // last
  // Configuration write port
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [mpd_pkg::DUR_W-1:0] cfg_wdata
);
  import mpd_pkg::*;

  mpd_state_t          state_r, state_nxt;
  logic [DUR_W-1:0]    dah_thr_r;
  logic [DUR_W-1:0]    fin_thr_r;
  logic [DUR_W-1:0]    dur_r, dur_nxt;
  logic                kind_r, kind_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                finished_r, finished_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [HASH_W-1:0]   prod_r, prod_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic                last_r, last_nxt;
  logic                space_pend_r, space_pend_nxt;

  logic                in_xfer;
  logic                out_xfer;
  logic [DUR_W-1:0]    cmp_thr;
  logic                cmp_gt;
  logic                cnt_full;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {1'b0, code_r};
  assign out_tlast  = last_r;

  assign in_xfer  = in_tvalid & in_tready;
  assign out_xfer = out_tvalid & out_tready;
  assign cnt_full = (cnt_r >= CNT_W'(MAX_SYMBOLS));

  // Shared comparator: finish threshold in its own step, dah otherwise
  assign cmp_thr = (state_r == ST_CMP_FIN) ? fin_thr_r : dah_thr_r;
  assign cmp_gt  = (dur_r > cmp_thr);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dah_thr_r <= DAH_THR_RESET;
      fin_thr_r <= FIN_THR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DAH_IDX: dah_thr_r <= cfg_wdata;
        CFG_FIN_IDX: fin_thr_r <= cfg_wdata;
        default:     dah_thr_r <= dah_thr_r;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hash_r       <= '0;
      cnt_r        <= '0;
      finished_r   <= 1'b0;
      space_pend_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hash_r       <= hash_nxt;
      cnt_r        <= cnt_nxt;
      finished_r   <= finished_nxt;
      space_pend_r <= space_pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dur_r    <= dur_nxt;
    kind_r   <= kind_nxt;
    weight_r <= weight_nxt;
    prod_r   <= prod_nxt;
    code_r   <= code_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    dur_nxt        = dur_r;
    kind_nxt       = kind_r;
    hash_nxt       = hash_r;
    cnt_nxt        = cnt_r;
    finished_nxt   = finished_r;
    weight_nxt     = weight_r;
    prod_nxt       = prod_r;
    code_nxt       = code_r;
    last_nxt       = last_r;
    space_pend_nxt = space_pend_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          dur_nxt  = in_tdata[DUR_W-1:0];
          kind_nxt = in_tuser;
          // Drop everything once the message has ended; a signal press past
          // the symbol limit changes nothing either
          if (!finished_r) begin
            if (in_tuser == REQ_CONTROL) begin
              state_nxt = ST_CMP_FIN;
            end else if (!cnt_full) begin
              state_nxt = ST_CMP_DAH;
            end
          end
        end
      end

      ST_CMP_FIN: begin
        if (cmp_gt) begin
          // End of message: pending letter is dropped
          code_nxt     = CHAR_END;
          last_nxt     = 1'b1;
          finished_nxt = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          state_nxt = ST_CMP_DAH;
        end
      end

      ST_CMP_DAH: begin
        if (kind_r == REQ_SIGNAL) begin
          weight_nxt = cmp_gt ? DAH_WEIGHT : DIT_WEIGHT;
          state_nxt  = ST_MUL;
        end else begin
          code_nxt       = cnt_full ? CHAR_UNKNOWN : lookup_char(hash_r);
          last_nxt       = !cmp_gt;
          space_pend_nxt = cmp_gt;
          hash_nxt       = '0;
          cnt_nxt        = '0;
          state_nxt      = ST_EMIT;
        end
      end

      ST_MUL: begin
        prod_nxt  = HASH_W'(weight_r) * HASH_W'(symbol_coef(cnt_r));
        state_nxt = ST_ACC;
      end

      ST_ACC: begin
        hash_nxt  = hash_r + prod_r;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_EMIT: begin
        if (out_xfer) begin
          if (space_pend_r) begin
            // Follow the letter with a space, which closes the transaction run
            code_nxt       = CHAR_SPACE;
            last_nxt       = 1'b1;
            space_pend_nxt = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
